// ===== design/dtg_pkg.sv =====
// Shared constants, types and elaboration-time tables of the DTMF tone generator.
// Depends on nothing; dtmf_tone_generator imports it.
`default_nettype none

package dtg_pkg;

    // Synthesis constants
    localparam int SAMPLE_RATE = 8000;
    localparam int TABLE_BITS  = 10;
    localparam int PHASE_BITS  = 32;
    localparam int QUARTER     = 1 << (TABLE_BITS - 2);

    // Field widths
    localparam int KEY_W    = 8;
    localparam int COUNT_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int SINE_W   = 16;
    localparam int SAMPLE_W = 17;
    localparam int SUM_W    = 32;
    localparam int PROD_W   = SUM_W + GAIN_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Opcodes of a command beat
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Peak levels in Q16: row at -11 dBm, column at -9 dBm
    localparam logic signed [SINE_W-1:0] LOW_PEAK_Q16  = 16'sd18468;
    localparam logic signed [SINE_W-1:0] HIGH_PEAK_Q16 = 16'sd23252;

    // Rounding and output limits
    localparam int ROUND_SHIFT = 31;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1073741824);
    localparam logic signed [PROD_W-ROUND_SHIFT-1:0] SAT_MAX = 18'sd65535;
    localparam logic signed [PROD_W-ROUND_SHIFT-1:0] SAT_MIN = -18'sd65536;

    // Taylor series constants for the quarter-wave table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // Single-entry state store
    localparam int STATE_DEPTH = 1;
    localparam int STATE_AW    = 1;
    localparam logic [STATE_AW-1:0] STATE_ADDR = '0;

    typedef struct packed {
        logic                  active;
        logic [COUNT_W-1:0]    position;
        logic [COUNT_W-1:0]    tone_end;
        logic [COUNT_W:0]      pause_end;
        logic [PHASE_BITS-1:0] low_phase;
        logic [PHASE_BITS-1:0] high_phase;
        logic [PHASE_BITS-1:0] low_inc;
        logic [PHASE_BITS-1:0] high_inc;
    } dtg_state_t;

    localparam int STATE_W = $bits(dtg_state_t);

    typedef struct packed {
        logic sample_valid;
        logic tone_done;
        logic start_status;
    } dtg_flags_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] row;
        logic [1:0] col;
    } dtg_key_t;

    typedef logic [QUARTER-1:0][SINE_W-2:0] sine_table_t;
    typedef logic [3:0][PHASE_BITS-1:0]     inc_table_t;

    // Q15 sine of quarter-wave step q, truncating Horner steps in Q30
    function automatic logic [SINE_W-2:0] quarter_sine(input logic [63:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (q * HALF_PI_Q30) >> (TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 0; k < 5; k++)
        begin
            t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[k]);
        end
        s = (x * t) >> 30;
        r = (s + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[SINE_W-2:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        for (int i = 0; i < QUARTER; i++)
        begin
            tbl[i] = quarter_sine(64'(i));
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();
    localparam logic [SINE_W-2:0] SINE_PEAK = quarter_sine(64'(QUARTER));

    // Phase increment, rounded: f * 2^PHASE_BITS / SAMPLE_RATE
    function automatic logic [PHASE_BITS-1:0] make_increment(input logic [31:0] hz);
        logic [63:0] num;
        num = ({32'd0, hz} << PHASE_BITS) + 64'(SAMPLE_RATE / 2);
        return PHASE_BITS'(num / SAMPLE_RATE);
    endfunction

    localparam inc_table_t ROW_INC = {make_increment(32'd941), make_increment(32'd852),
                                      make_increment(32'd770), make_increment(32'd697)};
    localparam inc_table_t COL_INC = {make_increment(32'd1633), make_increment(32'd1477),
                                      make_increment(32'd1336), make_increment(32'd1209)};

    // Map an ASCII key to its row and column
    function automatic dtg_key_t key_lookup(input logic [KEY_W-1:0] key);
        dtg_key_t k;
        unique case (key)
            "1":      k = '{1'b1, 2'd0, 2'd0};
            "2":      k = '{1'b1, 2'd0, 2'd1};
            "3":      k = '{1'b1, 2'd0, 2'd2};
            "A", "a": k = '{1'b1, 2'd0, 2'd3};
            "4":      k = '{1'b1, 2'd1, 2'd0};
            "5":      k = '{1'b1, 2'd1, 2'd1};
            "6":      k = '{1'b1, 2'd1, 2'd2};
            "B", "b": k = '{1'b1, 2'd1, 2'd3};
            "7":      k = '{1'b1, 2'd2, 2'd0};
            "8":      k = '{1'b1, 2'd2, 2'd1};
            "9":      k = '{1'b1, 2'd2, 2'd2};
            "C", "c": k = '{1'b1, 2'd2, 2'd3};
            "*":      k = '{1'b1, 2'd3, 2'd0};
            "0":      k = '{1'b1, 2'd3, 2'd1};
            "#":      k = '{1'b1, 2'd3, 2'd2};
            "D", "d": k = '{1'b1, 2'd3, 2'd3};
            default:  k = '{1'b0, 2'd0, 2'd0};
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== design/dtg_cmd_if.sv =====
// Command channel of the DTMF tone generator: valid, ready and one command beat.
// Depends on nothing.
`default_nettype none

interface dtg_cmd_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  key_code;
    logic [31:0] on_samples;
    logic [31:0] off_samples;

    modport source (output valid, output op, output key_code, output on_samples,
                    output off_samples, input ready);
    modport sink   (input valid, input op, input key_code, input on_samples,
                    input off_samples, output ready);
endinterface

`default_nettype wire

// ===== design/dtg_smp_if.sv =====
// Sample channel of the DTMF tone generator: valid, ready and one result beat.
// Depends on nothing.
`default_nettype none

interface dtg_smp_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] sample_out;
    logic               sample_valid;
    logic               tone_done;
    logic               start_status;

    modport source (output valid, output sample_out, output sample_valid,
                    output tone_done, output start_status, input ready);
    modport sink   (input valid, input sample_out, input sample_valid,
                    input tone_done, input start_status, output ready);
endinterface

`default_nettype wire

// ===== design/dtg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module dtg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write the array, read the old contents on a collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/dtmf_tone_generator.sv =====
// DTMF tone generator: two phase accumulators, a quarter-wave sine table, mixing and gain.
// A command beat passes through stage 1, the sine, sum and gain stages and the output register.
// Throughput: one command beat per cycle unless the sample side stalls; the state word goes through
// a single-entry RAM (read on accept, written when stage 1 moves on), forwarding the last write.
// Reset: gain returns to 1.0, the pipeline empties, and the state reads as zero until first written.
// Depends on dtg_pkg, dtg_cmd_if, dtg_smp_if and dtg_ram.
`default_nettype none

module dtmf_tone_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    dtg_cmd_if.sink                          tone_cmd,
    dtg_smp_if.source                        tone_sample,
    input  wire logic                        cfg_we,
    input  wire logic [dtg_pkg::GAIN_W-1:0]  cfg_wdata
);

    import dtg_pkg::*;

    // Signed Q15 sine from the top phase bits, by quarter-wave symmetry
    function automatic logic signed [SINE_W-1:0] sine_lookup(input logic [PHASE_BITS-1:0] ph);
        logic [TABLE_BITS-1:0] idx;
        logic [1:0]            quad;
        logic [TABLE_BITS-3:0] q;
        logic [TABLE_BITS-2:0] qq;
        logic [SINE_W-2:0]     mag;
        idx  = ph[PHASE_BITS-1 -: TABLE_BITS];
        quad = idx[TABLE_BITS-1 -: 2];
        q    = idx[TABLE_BITS-3:0];
        qq   = quad[0] ? ((TABLE_BITS-1)'(QUARTER) - {1'b0, q}) : {1'b0, q};
        mag  = qq[TABLE_BITS-2] ? SINE_PEAK : SINE_TABLE[qq[TABLE_BITS-3:0]];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    logic [GAIN_W-1:0] gain_reg;

    // Stage 1: command beat and state read
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [KEY_W-1:0]   s1_key_reg;
    logic [COUNT_W-1:0] s1_on_reg;
    logic [COUNT_W-1:0] s1_off_reg;
    logic               hazard_reg;
    logic               rd_ok_reg;
    logic               written_reg;
    dtg_state_t         fwd_reg;
    logic [STATE_W-1:0] state_rd;

    // Stage 2: sines
    logic                     s2_valid_reg;
    logic signed [SINE_W-1:0] s2_low_reg;
    logic signed [SINE_W-1:0] s2_high_reg;
    dtg_flags_t               s2_flags_reg;

    // Stage 3: weighted sum
    logic                    s3_valid_reg;
    logic signed [SUM_W-1:0] s3_sum_reg;
    dtg_flags_t              s3_flags_reg;

    // Stage 4: gain product
    logic                     s4_valid_reg;
    logic signed [PROD_W-1:0] s4_prod_reg;
    dtg_flags_t               s4_flags_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    dtg_flags_t                 out_flags_reg;

    logic out_free;
    logic s4_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic s1_fire;
    logic accept;

    dtg_state_t               cur_state;
    dtg_state_t               nxt_state;
    dtg_flags_t               s1_flags;
    logic signed [SINE_W-1:0] low_sine;
    logic signed [SINE_W-1:0] high_sine;
    dtg_key_t                 key_hit;
    logic [COUNT_W-1:0]       pos_inc;

    logic signed [SUM_W-1:0]                low_term;
    logic signed [SUM_W-1:0]                high_term;
    logic signed [PROD_W-1:0]               prod_next;
    logic signed [PROD_W-1:0]               rounded;
    logic signed [PROD_W-ROUND_SHIFT-1:0]   scaled;
    logic signed [SAMPLE_W-1:0]             sample_next;

    // Back-pressure chain: a stage loads when it is empty or moves on
    assign out_free = !out_valid_reg || tone_sample.ready;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign accept   = tone_cmd.valid && s1_free;

    assign tone_cmd.ready = s1_free;

    // Hold the gain register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_wdata;
        end
    end

    // State store: read on accept, write back when stage 1 moves on
    dtg_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (STATE_ADDR),
        .wr_data (nxt_state),
        .rd_en   (accept),
        .rd_addr (STATE_ADDR),
        .rd_data (state_rd)
    );

    // Track stage 1 occupancy and forwarding control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hazard_reg   <= 1'b0;
            rd_ok_reg    <= 1'b0;
            written_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (accept)
            begin
                hazard_reg <= s1_fire;
                rd_ok_reg  <= written_reg;
            end
            if (s1_fire)
            begin
                written_reg <= 1'b1;
            end
        end
    end

    // Capture the command beat and the word written alongside its read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= tone_cmd.op;
            s1_key_reg <= tone_cmd.key_code;
            s1_on_reg  <= tone_cmd.on_samples;
            s1_off_reg <= tone_cmd.off_samples;
            fwd_reg    <= nxt_state;
        end
    end

    // Pick the current state: forwarded write, stored word, or reset value
    always_comb
    begin
        if (hazard_reg)
        begin
            cur_state = fwd_reg;
        end
        else if (rd_ok_reg)
        begin
            cur_state = dtg_state_t'(state_rd);
        end
        else
        begin
            cur_state = '0;
        end
    end

    // Advance the oscillators, load a new tone, or stop on a bad key
    always_comb
    begin
        nxt_state = cur_state;
        s1_flags  = '0;
        low_sine  = '0;
        high_sine = '0;
        key_hit   = key_lookup(s1_key_reg);
        pos_inc   = cur_state.position + COUNT_W'(1);
        if (s1_op_reg == OP_START)
        begin
            if (!key_hit.hit)
            begin
                nxt_state.active      = 1'b0;
                s1_flags.start_status = 1'b1;
            end
            else
            begin
                nxt_state.active     = 1'b1;
                nxt_state.position   = '0;
                nxt_state.tone_end   = s1_on_reg;
                nxt_state.pause_end  = {1'b0, s1_on_reg} + {1'b0, s1_off_reg};
                nxt_state.low_inc    = ROW_INC[key_hit.row];
                nxt_state.high_inc   = COL_INC[key_hit.col];
                nxt_state.low_phase  = '0;
                nxt_state.high_phase = '0;
            end
        end
        else if (cur_state.active)
        begin
            low_sine              = sine_lookup(cur_state.low_phase);
            high_sine             = sine_lookup(cur_state.high_phase);
            s1_flags.sample_valid = 1'b1;
            nxt_state.low_phase   = cur_state.low_phase + cur_state.low_inc;
            nxt_state.high_phase  = cur_state.high_phase + cur_state.high_inc;
            nxt_state.position    = pos_inc;
            // Drop to silence at the end of the tone part
            if (pos_inc == cur_state.tone_end)
            begin
                nxt_state.low_phase  = '0;
                nxt_state.high_phase = '0;
                nxt_state.low_inc    = '0;
                nxt_state.high_inc   = '0;
            end
            // End the tone when the position reaches the pause end
            if ({1'b0, pos_inc} == cur_state.pause_end)
            begin
                nxt_state.active   = 1'b0;
                s1_flags.tone_done = 1'b1;
            end
        end
    end

    // Weight each sine by its peak level, apply gain, round and saturate
    assign low_term  = s2_low_reg * LOW_PEAK_Q16;
    assign high_term = s2_high_reg * HIGH_PEAK_Q16;
    assign prod_next = s3_sum_reg * $signed({1'b0, gain_reg});
    assign rounded   = s4_prod_reg + ROUND_HALF;
    assign scaled    = rounded[PROD_W-1:ROUND_SHIFT];

    always_comb
    begin
        if (scaled > SAT_MAX)
        begin
            sample_next = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (scaled < SAT_MIN)
        begin
            sample_next = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sample_next = scaled[SAMPLE_W-1:0];
        end
    end

    // Advance the valid bits of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= s1_fire;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Move the payload down the arithmetic stages
    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_low_reg   <= low_sine;
            s2_high_reg  <= high_sine;
            s2_flags_reg <= s1_flags;
        end
        if (s3_free)
        begin
            s3_sum_reg   <= low_term + high_term;
            s3_flags_reg <= s2_flags_reg;
        end
        if (s4_free)
        begin
            s4_prod_reg  <= prod_next;
            s4_flags_reg <= s3_flags_reg;
        end
        if (out_free)
        begin
            out_sample_reg <= sample_next;
            out_flags_reg  <= s4_flags_reg;
        end
    end

    // Drive the result beat
    assign tone_sample.valid        = out_valid_reg;
    assign tone_sample.sample_out   = out_sample_reg;
    assign tone_sample.sample_valid = out_flags_reg.sample_valid;
    assign tone_sample.tone_done    = out_flags_reg.tone_done;
    assign tone_sample.start_status = out_flags_reg.start_status;

endmodule

`default_nettype wire

// ===== tb/dtmf_tone_generator_test.sv =====
// Self-checking test of dtmf_tone_generator: directed tones, level settings, random traffic.
// Keeps its own dual-tone synthesis model and compares every sample beat against it.
// Depends on dtg_pkg, dtg_cmd_if, dtg_smp_if and the dtmf_tone_generator design.
`default_nettype none

module dtmf_tone_generator_test;

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  HOLD_STRETCH   = 300;
    localparam int  DRAIN_CYCLES   = 8;
    localparam int  SAMPLE_HZ      = 8000;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [63:0] UNIT_Q30         = 64'd1073741824;
    localparam logic [3:0][10:0] ROW_HZ = {11'd941, 11'd852, 11'd770, 11'd697};
    localparam logic [3:0][10:0] COL_HZ = {11'd1633, 11'd1477, 11'd1336, 11'd1209};
    localparam string DIAL_KEYS = "0123456789*#ABCDabcd";

    typedef struct packed {
        logic signed [16:0] sample;
        logic               sounding;
        logic               done;
        logic               bad_key;
    } tone_sample_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [dtg_pkg::GAIN_W-1:0] cfg_wdata;

    dtg_cmd_if tone_cmd ();
    dtg_smp_if tone_sample ();

    dtmf_tone_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tone_cmd    (tone_cmd),
        .tone_sample (tone_sample),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Model state of the generator
    logic        tone_on;
    logic [31:0] sample_pos;
    logic [31:0] tone_len_end;
    logic [32:0] pause_len_end;
    logic [31:0] row_phase;
    logic [31:0] col_phase;
    logic [31:0] row_step;
    logic [31:0] col_step;
    logic [15:0] level_model;

    tone_sample_t pending_samples[$];

    // Shared between the stimulus and the sample sink
    bit steady_flow;
    bit hold_request;

    int error_count;
    int beats_checked;
    int tones_finished;
    int tones_started;
    int bad_keys_sent;
    int levels_applied;
    int idle_cycles;

    // Q15 sine of a quarter-wave step, truncating Horner steps in Q30
    function automatic int quarter_wave(input int step);
        logic [63:0] arg;
        logic [63:0] arg_sq;
        logic [63:0] poly;
        logic [63:0] rounded;
        arg    = (64'(step) * QUARTER_TURN_Q30) >> 8;
        arg_sq = (arg * arg) >> 30;
        poly   = UNIT_Q30;
        // divisors 11*10, 9*8, 7*6, 5*4, 3*2
        for (int m = 5; m >= 1; m--)
        begin
            poly = UNIT_Q30 - (((arg_sq * poly) >> 30) / 64'((2 * m + 1) * (2 * m)));
        end
        rounded = (((arg * poly) >> 30) + 64'd16384) >> 15;
        if (rounded > 64'd32767)
        begin
            rounded = 64'd32767;
        end
        return int'(rounded);
    endfunction

    // Full-wave table value from the top ten phase bits
    function automatic int wave_value(input logic [31:0] phase);
        logic [9:0] idx;
        int         mag;
        idx = phase[31:22];
        mag = idx[8] ? quarter_wave(256 - int'(idx[7:0])) : quarter_wave(int'(idx[7:0]));
        return idx[9] ? -mag : mag;
    endfunction

    function automatic logic [31:0] phase_step(input logic [10:0] hz);
        return 32'(((64'(hz) << 32) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ));
    endfunction

    function automatic bit dial_lookup(input logic [7:0] key, output logic [1:0] row,
                                       output logic [1:0] col);
        dial_lookup = 1'b1;
        row = 2'd0;
        col = 2'd0;
        case (key)
            "1":      {row, col} = {2'd0, 2'd0};
            "2":      {row, col} = {2'd0, 2'd1};
            "3":      {row, col} = {2'd0, 2'd2};
            "A", "a": {row, col} = {2'd0, 2'd3};
            "4":      {row, col} = {2'd1, 2'd0};
            "5":      {row, col} = {2'd1, 2'd1};
            "6":      {row, col} = {2'd1, 2'd2};
            "B", "b": {row, col} = {2'd1, 2'd3};
            "7":      {row, col} = {2'd2, 2'd0};
            "8":      {row, col} = {2'd2, 2'd1};
            "9":      {row, col} = {2'd2, 2'd2};
            "C", "c": {row, col} = {2'd2, 2'd3};
            "*":      {row, col} = {2'd3, 2'd0};
            "0":      {row, col} = {2'd3, 2'd1};
            "#":      {row, col} = {2'd3, 2'd2};
            "D", "d": {row, col} = {2'd3, 2'd3};
            default:  dial_lookup = 1'b0;
        endcase
    endfunction

    // Advance the model by one command beat and return the sample it produces
    function automatic tone_sample_t next_sample(input logic op, input logic [7:0] key,
                                                 input logic [31:0] on_n,
                                                 input logic [31:0] off_n);
        tone_sample_t res;
        logic [1:0]   row;
        logic [1:0]   col;
        longint       mix;
        longint       level;
        res = '0;
        if (op == dtg_pkg::OP_START)
        begin
            if (!dial_lookup(key, row, col))
            begin
                tone_on = 1'b0;
                res.bad_key = 1'b1;
                bad_keys_sent++;
            end
            else
            begin
                tone_on       = 1'b1;
                sample_pos    = '0;
                tone_len_end  = on_n;
                pause_len_end = {1'b0, on_n} + {1'b0, off_n};
                row_step      = phase_step(ROW_HZ[row]);
                col_step      = phase_step(COL_HZ[col]);
                row_phase     = '0;
                col_phase     = '0;
                tones_started++;
            end
            return res;
        end
        if (!tone_on)
        begin
            return res;
        end
        mix = longint'(wave_value(row_phase)) * 18468 + longint'(wave_value(col_phase)) * 23252;
        mix = mix * longint'({48'd0, level_model});
        level = (mix + 64'sd1073741824) >>> 31;
        if (level > 65535)
        begin
            level = 65535;
        end
        if (level < -65536)
        begin
            level = -65536;
        end
        row_phase  = row_phase + row_step;
        col_phase  = col_phase + col_step;
        sample_pos = sample_pos + 32'd1;
        // silence once the tone part is over
        if (sample_pos == tone_len_end)
        begin
            row_phase = '0;
            col_phase = '0;
            row_step  = '0;
            col_step  = '0;
        end
        if ({1'b0, sample_pos} == pause_len_end)
        begin
            tone_on  = 1'b0;
            res.done = 1'b1;
        end
        res.sample   = level[16:0];
        res.sounding = 1'b1;
        return res;
    endfunction

    // Predict on every accepted command beat
    always @(posedge clk)
    begin
        if (rst_n && tone_cmd.valid && tone_cmd.ready)
        begin
            pending_samples.push_back(next_sample(tone_cmd.op, tone_cmd.key_code,
                                                  tone_cmd.on_samples, tone_cmd.off_samples));
        end
    end

    // Compare every accepted sample beat with the oldest prediction
    always @(posedge clk)
    begin : check_beat
        tone_sample_t want;
        bit           bad;
        if (rst_n && tone_sample.valid && tone_sample.ready)
        begin
            beats_checked++;
            if (pending_samples.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected sample beat, expected none, got sample %0d",
                         $time, tone_sample.sample_out);
            end
            else
            begin
                want = pending_samples.pop_front();
                bad  = 1'b0;
                if (want.done)
                begin
                    tones_finished++;
                end
                if (tone_sample.sample_out !== want.sample)
                begin
                    bad = 1'b1;
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, want.sample, tone_sample.sample_out);
                end
                if (tone_sample.sample_valid !== want.sounding)
                begin
                    bad = 1'b1;
                    $display("%0t: sample_valid expected %0b, got %0b",
                             $time, want.sounding, tone_sample.sample_valid);
                end
                if (tone_sample.tone_done !== want.done)
                begin
                    bad = 1'b1;
                    $display("%0t: tone_done expected %0b, got %0b",
                             $time, want.done, tone_sample.tone_done);
                end
                if (tone_sample.start_status !== want.bad_key)
                begin
                    bad = 1'b1;
                    $display("%0t: start_status expected %0b, got %0b",
                             $time, want.bad_key, tone_sample.start_status);
                end
                if (bad)
                begin
                    error_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((tone_cmd.valid && tone_cmd.ready) || (tone_sample.valid && tone_sample.ready)
            || cfg_we)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Sample sink: random stalls per beat, one long hold when requested
    initial
    begin : sample_sink
        int stall;
        tone_sample.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = HOLD_STRETCH;
                hold_request = 1'b0;
            end
            else
            begin
                stall = steady_flow ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0)
            begin
                tone_sample.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tone_sample.ready <= 1'b1;
            do @(posedge clk); while (!tone_sample.valid);
        end
    end

    // Offer one command beat and hold it until accepted
    task automatic send_command(input logic op, input logic [7:0] key,
                                input logic [31:0] on_n, input logic [31:0] off_n);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            tone_cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tone_cmd.valid       <= 1'b1;
        tone_cmd.op          <= op;
        tone_cmd.key_code    <= key;
        tone_cmd.on_samples  <= on_n;
        tone_cmd.off_samples <= off_n;
        do @(posedge clk); while (!tone_cmd.ready);
    endtask

    // Tick with random content in the ignored fields
    task automatic send_tick();
        send_command(dtg_pkg::OP_TICK, 8'($urandom_range(0, 255)), $urandom, $urandom);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipeline settle
    task automatic wait_until_drained();
        tone_cmd.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_level(input logic [15:0] gain);
        cfg_wdata <= gain;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        level_model = gain;
        levels_applied++;
    endtask

    task automatic test_idle_tick_and_bad_key();
        send_tick();
        send_command(dtg_pkg::OP_START, 8'h00, 32'd0, 32'd0);
    endtask

    // Tone, silence with the done flag, then an idle tick
    task automatic test_single_tone();
        send_command(dtg_pkg::OP_START, "1", 32'd2, 32'd1);
        repeat (4) send_tick();
    endtask

    task automatic test_zero_pause();
        send_command(dtg_pkg::OP_START, "D", 32'd1, 32'd0);
        send_tick();
    endtask

    task automatic test_restart_while_active();
        send_command(dtg_pkg::OP_START, "#", 32'd5, 32'd5);
        repeat (2) send_tick();
        send_command(dtg_pkg::OP_START, "a", 32'd1, 32'd1);
        repeat (3) send_tick();
    endtask

    task automatic test_bad_key_while_active();
        send_command(dtg_pkg::OP_START, "*", 32'd3, 32'd3);
        send_tick();
        send_command(dtg_pkg::OP_START, 8'h80, 32'd7, 32'd7);
        send_tick();
    endtask

    // Zero tone length: the tone keeps sounding until the pause ends
    task automatic test_zero_tone_length();
        send_command(dtg_pkg::OP_START, "0", 32'd0, 32'd2);
        repeat (3) send_tick();
    endtask

    // Pause end beyond the 32-bit counter: never reached
    task automatic test_endless_pause();
        send_command(dtg_pkg::OP_START, "9", 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (3) send_tick();
    endtask

    // Mostly well-formed tones with random content, some broken ones and noise
    task automatic run_random_calls(input int budget);
        int          sent;
        int          ticks;
        int          pick;
        logic [7:0]  key;
        logic [31:0] on_n;
        logic [31:0] off_n;
        sent = 0;
        while (sent < budget)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            key  = DIAL_KEYS[$urandom_range(0, 19)];
            if (pick < 80)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    on_n  = $urandom;
                    off_n = $urandom;
                    ticks = $urandom_range(1, 40);
                end
                else
                begin
                    on_n  = $urandom_range(0, 24);
                    off_n = $urandom_range(0, 24);
                    ticks = int'(on_n + off_n) + $urandom_range(0, 2);
                    // cut some tones short with the next start
                    if ($urandom_range(0, 9) == 0)
                    begin
                        ticks = $urandom_range(0, ticks);
                    end
                end
            end
            else if (pick < 92)
            begin
                key   = 8'($urandom_range(0, 255));
                on_n  = $urandom;
                off_n = $urandom;
                ticks = $urandom_range(0, 4);
            end
            else
            begin
                ticks = $urandom_range(1, 6);
            end
            if (pick < 92)
            begin
                send_command(dtg_pkg::OP_START, key, on_n, off_n);
                sent++;
            end
            repeat (ticks)
            begin
                send_tick();
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    // Random traffic under a sweep of output levels, extremes included
    task automatic test_level_settings();
        logic [15:0] levels [7];
        levels = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom), 16'h8000,
                   16'($urandom), dtg_pkg::GAIN_RESET};
        foreach (levels[i])
        begin
            wait_until_drained();
            set_level(levels[i]);
            run_random_calls(215);
        end
    endtask

    // Hold the sink for a long stretch while commands keep coming
    task automatic test_output_stall();
        wait_until_drained();
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        send_command(dtg_pkg::OP_START, "5", 32'd40, 32'd30);
        repeat (80) send_tick();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        tone_cmd.valid       <= 1'b0;
        tone_cmd.op          <= dtg_pkg::OP_TICK;
        tone_cmd.key_code    <= '0;
        tone_cmd.on_samples  <= '0;
        tone_cmd.off_samples <= '0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        tone_on       = 1'b0;
        sample_pos    = '0;
        tone_len_end  = '0;
        pause_len_end = '0;
        row_phase     = '0;
        col_phase     = '0;
        row_step      = '0;
        col_step      = '0;
        level_model   = dtg_pkg::GAIN_RESET;
        steady_flow   = 1'b0;
        hold_request  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_tick_and_bad_key();
        test_single_tone();
        test_zero_pause();
        test_restart_while_active();
        test_bad_key_while_active();
        test_zero_tone_length();
        test_endless_pause();
        test_level_settings();
        test_output_stall();
        wait_until_drained();

        $display("Checked %0d sample beats: %0d tones started, %0d finished, %0d bad keys,",
                 beats_checked, tones_started, tones_finished, bad_keys_sent);
        $display("over %0d level settings and one long output stall", levels_applied);
        if (error_count == 0 && pending_samples.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== dtmf_tone_generator.f =====
design/dtg_pkg.sv
design/dtg_cmd_if.sv
design/dtg_smp_if.sv
design/dtg_ram.sv
design/dtmf_tone_generator.sv
tb/dtmf_tone_generator_test.sv
